// ===== rtl/tga_pkg.sv =====
`timescale 1ns / 1ps

package tga_pkg;

  // Depth of the command queue between the parser and the result stage.
  localparam int TGA_QUEUE_DEPTH = 2;

  // Header layout. The descriptor byte (the last one) is checked as it
  // arrives, so only the bytes in front of it are stored.
  localparam int HDR_LEN   = 18;
  localparam int HDR_STORE = HDR_LEN - 1;
  localparam int HS_AW     = $clog2(HDR_STORE);

  localparam logic [7:0] ENC_RAW        = 8'd2;
  localparam logic [7:0] ENC_RLE        = 8'd10;
  localparam logic [7:0] MAX_DESCRIPTOR = 8'd32;
  localparam logic [7:0] ALPHA_CLEAR    = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [7:0] RUN_BIAS       = 8'd127;
  localparam logic [4:0] BPP_MAX        = 5'd4;
  localparam logic [2:0] BPP_ALPHA      = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_COLORMAP    = 3'd1;
  localparam logic [2:0] ST_ENCODING    = 3'd2;
  localparam logic [2:0] ST_SIZE        = 3'd3;
  localparam logic [2:0] ST_DEPTH       = 3'd4;
  localparam logic [2:0] ST_INTERLEAVED = 3'd5;
  localparam logic [2:0] ST_MAP_ENTRIES = 3'd6;
  localparam logic [2:0] ST_TRUNCATED   = 3'd7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_PKTHEAD,
    PH_PIXEL,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_PIXEL_BYTE,
    CMD_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  status;
    logic [7:0]  data;
    logic [1:0]  byte_idx;
    logic        last;
    logic [7:0]  rep;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  bpp;
    logic        alpha;
    logic        trans;
    logic        eoi;
  } cmd_t;

endpackage

// ===== rtl/tga_if.sv =====
`timescale 1ns / 1ps

interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  bytes_per_pixel;
  logic        has_alpha;
  logic        translucent;
  logic        end_of_image;

  modport source(output valid, kind, status, pixel_value, repeat_count, image_width,
                 image_height, bytes_per_pixel, has_alpha, translucent, end_of_image,
                 input ready);
  modport sink(input valid, kind, status, pixel_value, repeat_count, image_width,
               image_height, bytes_per_pixel, has_alpha, translucent, end_of_image,
               output ready);
endinterface

// ===== rtl/tga_front.sv =====
`timescale 1ns / 1ps

module tga_front
  import tga_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  tga_in_if.sink   in_ch,
  input  logic     space,
  output logic     cmd_push,
  output cmd_t     cmd
);

  phase_t      phase, phase_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [7:0]  hs [HDR_STORE];
  logic [1:0]  pix_idx, pix_idx_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_run, packet_run_next;
  logic [31:0] remaining, remaining_next;
  logic        translucent, translucent_next;
  logic        is_rle, is_rle_next;
  logic [2:0]  bpp, bpp_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] x1, y1, x2, y2, width, height;
  logic [31:0] area;
  logic [4:0]  hdr_bpp;
  logic [2:0]  hdr_err;
  logic        hdr_rle;

  logic        last;
  logic        trans_hit;
  logic [7:0]  rep_raw, rep;
  logic [31:0] rem_after;
  logic [7:0]  left_after;
  logic        pending;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  assign x1      = {hs[9], hs[8]};
  assign y1      = {hs[11], hs[10]};
  assign x2      = {hs[13], hs[12]};
  assign y2      = {hs[15], hs[14]};
  assign width   = x2 - x1;
  assign height  = y2 - y1;
  assign area    = {16'd0, width} * {16'd0, height};
  assign hdr_bpp = hs[16][7:3];
  assign hdr_rle = (hs[2] == ENC_RLE);

  // Checks in priority order; the descriptor is the byte on the input now.
  always_comb begin
    if (hs[1] != 8'd0) begin
      hdr_err = ST_COLORMAP;
    end else if (hs[2] != ENC_RAW && hs[2] != ENC_RLE) begin
      hdr_err = ST_ENCODING;
    end else if (x2 <= x1 || y2 <= y1) begin
      hdr_err = ST_SIZE;
    end else if (hs[16][2:0] != 3'd0 || hdr_bpp == 5'd0 || hdr_bpp > BPP_MAX) begin
      hdr_err = ST_DEPTH;
    end else if (b > MAX_DESCRIPTOR) begin
      hdr_err = ST_INTERLEAVED;
    end else if ({hs[5], hs[4]} != 16'd0) begin
      hdr_err = ST_MAP_ENTRIES;
    end else begin
      hdr_err = ST_OK;
    end
  end

  // Pixel completion: repeat count clamped to the pixels still owed.
  assign last       = ({1'b0, pix_idx} + 3'd1) >= bpp;
  assign trans_hit  = (bpp == BPP_ALPHA) && last && b != ALPHA_CLEAR && b != ALPHA_OPAQUE;
  assign rep_raw    = (is_rle && packet_run) ? packet_left : 8'd1;
  assign rep        = (remaining < {24'd0, rep_raw}) ? remaining[7:0] : rep_raw;
  assign rem_after  = remaining - {24'd0, rep};
  assign left_after = packet_run ? 8'd0 : packet_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    pix_idx_next      = pix_idx;
    packet_left_next  = packet_left;
    packet_run_next   = packet_run;
    remaining_next    = remaining;
    translucent_next  = translucent;
    is_rle_next       = is_rle;
    bpp_next          = bpp;
    cmd_push          = 1'b0;
    cmd               = '0;
    pending           = 1'b1;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (byte_counter == 8'(HDR_STORE)) begin
            cmd_push = 1'b1;
            if (hdr_err != ST_OK) begin
              cmd.op     = CMD_ERROR;
              cmd.status = hdr_err;
              phase_next = PH_DRAIN;
              pending    = 1'b0;
            end else begin
              cmd.op            = CMD_HEADER;
              cmd.status        = ST_OK;
              cmd.width         = width;
              cmd.height        = height;
              cmd.bpp           = hdr_bpp[2:0];
              cmd.alpha         = (hdr_bpp[2:0] == BPP_ALPHA);
              remaining_next    = area;
              translucent_next  = 1'b0;
              is_rle_next       = hdr_rle;
              bpp_next          = hdr_bpp[2:0];
              byte_counter_next = hs[0];
              packet_left_next  = 8'd0;
              packet_run_next   = 1'b0;
              pix_idx_next      = 2'd0;
              if (hs[0] != 8'd0) begin
                phase_next = PH_IDSKIP;
              end else begin
                phase_next = hdr_rle ? PH_PKTHEAD : PH_PIXEL;
              end
            end
          end else begin
            byte_counter_next = byte_counter + 8'd1;
          end
        end
        PH_IDSKIP: begin
          byte_counter_next = byte_counter - 8'd1;
          if (byte_counter == 8'd1) begin
            phase_next = is_rle ? PH_PKTHEAD : PH_PIXEL;
          end
        end
        PH_PKTHEAD: begin
          packet_run_next  = b[7];
          packet_left_next = b[7] ? b - RUN_BIAS : b + 8'd1;
          phase_next       = PH_PIXEL;
        end
        PH_PIXEL: begin
          translucent_next = translucent | trans_hit;
          cmd_push         = 1'b1;
          cmd.op           = CMD_PIXEL_BYTE;
          cmd.status       = ST_OK;
          cmd.data         = b;
          cmd.byte_idx     = pix_idx;
          cmd.last         = last;
          if (!last) begin
            pix_idx_next = pix_idx + 2'd1;
          end else begin
            pix_idx_next     = 2'd0;
            remaining_next   = rem_after;
            packet_left_next = is_rle ? left_after : packet_left;
            cmd.rep          = rep;
            cmd.trans        = translucent | trans_hit;
            cmd.eoi          = (rem_after == 32'd0);
            if (rem_after == 32'd0) begin
              phase_next = PH_DRAIN;
              pending    = 1'b0;
            end else if (is_rle && left_after == 8'd0) begin
              phase_next = PH_PKTHEAD;
            end
          end
        end
        default: begin
          pending = 1'b0;
        end
      endcase

      if (in_ch.end_of_file) begin
        if (pending) begin
          cmd        = '0;
          cmd.op     = CMD_ERROR;
          cmd.status = ST_TRUNCATED;
          cmd_push   = 1'b1;
        end
        phase_next        = PH_HEADER;
        byte_counter_next = 8'd0;
        pix_idx_next      = 2'd0;
        packet_left_next  = 8'd0;
        packet_run_next   = 1'b0;
        remaining_next    = 32'd0;
        translucent_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_counter <= 8'd0;
      pix_idx      <= 2'd0;
      packet_left  <= 8'd0;
      packet_run   <= 1'b0;
      remaining    <= 32'd0;
      translucent  <= 1'b0;
      is_rle       <= 1'b0;
      bpp          <= 3'd0;
    end else begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      pix_idx      <= pix_idx_next;
      packet_left  <= packet_left_next;
      packet_run   <= packet_run_next;
      remaining    <= remaining_next;
      translucent  <= translucent_next;
      is_rle       <= is_rle_next;
      bpp          <= bpp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER && byte_counter < 8'(HDR_STORE)) begin
      hs[byte_counter[HS_AW-1:0]] <= b;
    end
  end

endmodule

// ===== rtl/tga_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tga_cmd_fifo
  import tga_pkg::*;
#(
  parameter int DEPTH = TGA_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tga_back.sv =====
`timescale 1ns / 1ps

module tga_back
  import tga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  tga_out_if.source out_ch
);

  logic [31:0] assembly;
  logic [31:0] pixel;
  logic        produces;
  logic        out_free;
  logic        out_valid;
  kind_t       kind;
  logic [2:0]  status;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic [15:0] image_width, image_height;
  logic [2:0]  bytes_per_pixel;
  logic        has_alpha, translucent, end_of_image;

  assign pixel    = assembly | ({24'd0, cmd.data} << {cmd.byte_idx, 3'b000});
  assign produces = (cmd.op != CMD_PIXEL_BYTE) || cmd.last;
  assign out_free = !out_valid || out_ch.ready;
  assign cmd_pop  = cmd_valid && (!produces || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      assembly  <= 32'd0;
    end else begin
      if (cmd_pop && produces) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop) begin
        case (cmd.op)
          CMD_PIXEL_BYTE: begin
            assembly <= cmd.last ? 32'd0 : pixel;
          end
          default: begin
            assembly <= 32'd0;
          end
        endcase
      end
    end
  end

  // Result payload; pixel fields stay zero on header and error reports.
  always_ff @(posedge clk) begin
    if (cmd_pop && produces) begin
      status          <= cmd.status;
      image_width     <= cmd.width;
      image_height    <= cmd.height;
      bytes_per_pixel <= cmd.bpp;
      has_alpha       <= cmd.alpha;
      translucent     <= cmd.trans;
      end_of_image    <= cmd.eoi;
      repeat_count    <= cmd.rep;
      case (cmd.op)
        CMD_PIXEL_BYTE: begin
          kind        <= KIND_PIXEL;
          pixel_value <= pixel;
        end
        CMD_HEADER: begin
          kind        <= KIND_HEADER;
          pixel_value <= 32'd0;
        end
        default: begin
          kind        <= KIND_ERROR;
          pixel_value <= 32'd0;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = kind;
  assign out_ch.status          = status;
  assign out_ch.pixel_value     = pixel_value;
  assign out_ch.repeat_count    = repeat_count;
  assign out_ch.image_width     = image_width;
  assign out_ch.image_height    = image_height;
  assign out_ch.bytes_per_pixel = bytes_per_pixel;
  assign out_ch.has_alpha       = has_alpha;
  assign out_ch.translucent     = translucent;
  assign out_ch.end_of_image    = end_of_image;

endmodule

// ===== rtl/tga_stream_decoder.sv =====
`timescale 1ns / 1ps

// Streaming TGA decoder: takes the file one byte per transfer and reports a header
// result, pixel runs (value plus repeat count, raw or RLE images) or an error report,
// at most one result per byte. The input sustains one byte per clock whenever the
// result side keeps up; the parser hands its work to the result stage through a
// QUEUE_DEPTH-entry command queue, and the result stage registers each result
// that it takes from the queue. Bytes that need no work (ID field, packet headers,
// trailing bytes) give no result. Stalls on the output fill the queue and then hold
// off the input. There is no clearing pass after reset; the block accepts bytes in
// the first cycle after it.
module tga_stream_decoder
  import tga_pkg::*;
#(
  parameter int QUEUE_DEPTH = TGA_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  tga_in_if.sink    in_ch,
  tga_out_if.source out_ch
);

  cmd_t push_cmd, head_cmd;
  logic push, full, head_valid, pop;

  tga_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .space    (!full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  tga_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (head_valid),
    .pop_data  (head_cmd)
  );

  tga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/tga_checker.sv =====
`timescale 1ns / 1ps

module tga_checker
  import tga_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [2:0]  status,
  input logic [7:0]  repeat_count,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic [2:0]  bytes_per_pixel,
  input logic        has_alpha,
  input logic        translucent,
  input logic        end_of_image
);

  // A stalled result keeps its place, its kind, its status and its repeat count.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
      && $stable(repeat_count))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_pixel_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PIXEL |-> repeat_count != 8'd0 && status == ST_OK)
    else $error("pixel run without a repeat count");

  a_non_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PIXEL |-> repeat_count == 8'd0 && !end_of_image
      && !translucent)
    else $error("pixel fields set on a non-pixel result");

  a_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER |-> bytes_per_pixel != 3'd0
      && bytes_per_pixel <= BPP_ALPHA && has_alpha == (bytes_per_pixel == BPP_ALPHA)
      && image_width != 16'd0 && image_height != 16'd0)
    else $error("header result with impossible geometry");

endmodule

bind tga_stream_decoder tga_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .kind            (out_ch.kind),
  .status          (out_ch.status),
  .repeat_count    (out_ch.repeat_count),
  .image_width     (out_ch.image_width),
  .image_height    (out_ch.image_height),
  .bytes_per_pixel (out_ch.bytes_per_pixel),
  .has_alpha       (out_ch.has_alpha),
  .translucent     (out_ch.translucent),
  .end_of_image    (out_ch.end_of_image)
);

// ===== test/tga_stream_decoder_tb.sv =====
`timescale 1ns / 1ps

module tga_stream_decoder_tb;
  import tga_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  status;
    logic [31:0] pixel;
    logic [7:0]  reps;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  bpp;
    logic        alpha;
    logic        trans;
    logic        eoi;
  } decoded_t;

  logic clk;
  logic rst;

  tga_in_if  in_ch();
  tga_out_if out_ch();

  tga_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decoder state as seen from outside.
  phase_t      dec_phase;
  logic [7:0]  hdr_count;
  logic [7:0]  hdr [HDR_LEN];
  logic [31:0] pix_acc;
  logic [1:0]  pix_idx;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [31:0] pix_left;
  logic        trans_flag;

  decoded_t    expected_reports [$];
  logic [7:0]  file_bytes [$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          ready_hold = 0;
  bit          idle_on = 1'b1;

  function automatic void restart_decoder();
    dec_phase  = PH_HEADER;
    hdr_count  = '0;
    pix_acc    = '0;
    pix_idx    = '0;
    pkt_left   = '0;
    pkt_run    = 1'b0;
    pix_left   = '0;
    trans_flag = 1'b0;
  endfunction

  function automatic void start_pixels();
    dec_phase = (hdr[2] == ENC_RLE) ? PH_PKTHEAD : PH_PIXEL;
    pkt_left  = '0;
    pkt_run   = 1'b0;
    pix_idx   = '0;
    pix_acc   = '0;
  endfunction

  function automatic logic [2:0] header_status();
    logic [15:0] x1, y1, x2, y2;
    logic [4:0]  bpp;
    x1  = {hdr[9], hdr[8]};
    y1  = {hdr[11], hdr[10]};
    x2  = {hdr[13], hdr[12]};
    y2  = {hdr[15], hdr[14]};
    bpp = hdr[16][7:3];
    if (hdr[1] != 8'd0) return ST_COLORMAP;
    if (hdr[2] != ENC_RAW && hdr[2] != ENC_RLE) return ST_ENCODING;
    if (x2 <= x1 || y2 <= y1) return ST_SIZE;
    if (hdr[16][2:0] != 3'd0 || bpp == 5'd0 || bpp > BPP_MAX) return ST_DEPTH;
    if (hdr[17] > MAX_DESCRIPTOR) return ST_INTERLEAVED;
    if ({hdr[5], hdr[4]} != 16'd0) return ST_MAP_ENTRIES;
    return ST_OK;
  endfunction

  // Advances the decoder by one accepted byte and queues the report it causes.
  task automatic decode_byte(input logic [7:0] b, input logic eof);
    decoded_t    r;
    logic        have;
    logic        pending;
    logic [2:0]  err;
    logic [15:0] w, h;
    logic [2:0]  bpp;
    logic [1:0]  idx;
    logic [31:0] reps;
    r       = '0;
    have    = 1'b0;
    pending = 1'b1;
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_count < HDR_LEN) hdr[hdr_count] = b;
        hdr_count++;
        if (hdr_count >= HDR_LEN) begin
          err = header_status();
          have = 1'b1;
          if (err != ST_OK) begin
            r.kind    = KIND_ERROR;
            r.status  = err;
            dec_phase = PH_DRAIN;
            pending   = 1'b0;
          end else begin
            w = {hdr[13], hdr[12]} - {hdr[9], hdr[8]};
            h = {hdr[15], hdr[14]} - {hdr[11], hdr[10]};
            bpp = hdr[16][5:3];
            r.kind   = KIND_HEADER;
            r.width  = w;
            r.height = h;
            r.bpp    = bpp;
            r.alpha  = (bpp == BPP_ALPHA);
            pix_left   = 32'(w) * 32'(h);
            trans_flag = 1'b0;
            hdr_count  = hdr[0];
            if (hdr_count != 8'd0) dec_phase = PH_IDSKIP;
            else start_pixels();
          end
        end
      end
      PH_IDSKIP: begin
        hdr_count--;
        if (hdr_count == 8'd0) start_pixels();
      end
      PH_PKTHEAD: begin
        pkt_run   = b[7];
        pkt_left  = pkt_run ? b - RUN_BIAS : b + 8'd1;
        dec_phase = PH_PIXEL;
      end
      PH_PIXEL: begin
        bpp = hdr[16][5:3];
        idx = pix_idx;
        pix_acc = pix_acc | (32'(b) << (8 * idx));
        if (idx + 1 < bpp) begin
          pix_idx = idx + 2'd1;
        end else begin
          reps = 32'd1;
          if (bpp == BPP_ALPHA && pix_acc[31:24] != ALPHA_CLEAR &&
              pix_acc[31:24] != ALPHA_OPAQUE) trans_flag = 1'b1;
          if (hdr[2] == ENC_RLE) begin
            if (pkt_run) begin
              reps     = 32'(pkt_left);
              pkt_left = '0;
            end else begin
              pkt_left = pkt_left - 8'd1;
            end
          end
          // A run never reaches past the last pixel of the image.
          if (reps > pix_left) reps = pix_left;
          pix_left = pix_left - reps;
          r.kind  = KIND_PIXEL;
          r.pixel = pix_acc;
          r.reps  = reps[7:0];
          r.trans = trans_flag;
          r.eoi   = (pix_left == 32'd0);
          have    = 1'b1;
          pix_acc = '0;
          pix_idx = '0;
          if (pix_left == 32'd0) begin
            dec_phase = PH_DRAIN;
            pending   = 1'b0;
          end else if (hdr[2] == ENC_RLE && pkt_left == 8'd0) begin
            dec_phase = PH_PKTHEAD;
          end
        end
      end
      default: pending = 1'b0;
    endcase
    if (eof) begin
      // An early end of file replaces whatever this byte would have reported.
      if (pending) begin
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = ST_TRUNCATED;
        have     = 1'b1;
      end
      restart_decoder();
    end
    if (have) expected_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.end_of_file);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                   $time, out_ch.kind, out_ch.status);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("status", want.status, out_ch.status);
          check_field("pixel_value", want.pixel, out_ch.pixel_value);
          check_field("repeat_count", want.reps, out_ch.repeat_count);
          check_field("image_width", want.width, out_ch.image_width);
          check_field("image_height", want.height, out_ch.image_height);
          check_field("bytes_per_pixel", want.bpp, out_ch.bytes_per_pixel);
          check_field("has_alpha", want.alpha, out_ch.has_alpha);
          check_field("translucent", want.trans, out_ch.translucent);
          check_field("end_of_image", want.eoi, out_ch.end_of_image);
        end
        ready_hold = idle_on ? $urandom_range(0, 10) : 0;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_header(input logic [7:0] id_len, input logic [7:0] cmap,
                             input logic [7:0] enc, input logic [15:0] map_len,
                             input logic [15:0] x1, input logic [15:0] y1,
                             input logic [15:0] x2, input logic [15:0] y2,
                             input logic [7:0] depth, input logic [7:0] desc);
    file_bytes.push_back(id_len);
    file_bytes.push_back(cmap);
    file_bytes.push_back(enc);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(map_len[7:0]);
    file_bytes.push_back(map_len[15:8]);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(x1[7:0]);
    file_bytes.push_back(x1[15:8]);
    file_bytes.push_back(y1[7:0]);
    file_bytes.push_back(y1[15:8]);
    file_bytes.push_back(x2[7:0]);
    file_bytes.push_back(x2[15:8]);
    file_bytes.push_back(y2[7:0]);
    file_bytes.push_back(y2[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(desc);
    repeat (id_len) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_pixel(input int bpp);
    for (int i = 0; i < bpp; i++) begin
      if (bpp == 4 && i == 3) begin
        case ($urandom_range(0, 3))
          0:       file_bytes.push_back(ALPHA_CLEAR);
          1:       file_bytes.push_back(ALPHA_OPAQUE);
          default: file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end else begin
        file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Packets may overshoot the image now and then to exercise run clamping.
  task automatic push_rle(input int count, input int bpp);
    int left;
    int n;
    left = count;
    while (left > 0) begin
      n = $urandom_range(1, (left < 128) ? left : 128);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 128);
      if ($urandom_range(0, 1) == 1) begin
        file_bytes.push_back(8'(8'h80 | (n - 1)));
        push_pixel(bpp);
      end else begin
        file_bytes.push_back(8'(n - 1));
        repeat (n) push_pixel(bpp);
      end
      left = (n >= left) ? 0 : left - n;
    end
  endtask

  task automatic push_random_image();
    int w, h, bpp, sel;
    logic [7:0]  id_len;
    logic [15:0] x1, y1;
    bit rle;
    w   = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
    h   = $urandom_range(1, 4);
    bpp = $urandom_range(1, 4);
    rle = $urandom_range(0, 1);
    sel = $urandom_range(0, 31);
    id_len = (sel == 0) ? 8'd255 : (sel < 6) ? 8'($urandom_range(1, 6)) : 8'd0;
    x1 = 16'($urandom_range(0, 65535 - w));
    y1 = 16'($urandom_range(0, 65535 - h));
    push_header(id_len, 8'd0, rle ? ENC_RLE : ENC_RAW, 16'd0, x1, y1, x1 + 16'(w),
                y1 + 16'(h), 8'(bpp * 8), 8'($urandom_range(0, 32)));
    if (rle) push_rle(w * h, bpp);
    else repeat (w * h) push_pixel(bpp);
    if ($urandom_range(0, 2) == 0) push_noise($urandom_range(1, 4));
  endtask

  task automatic test_header_checks();
    logic [7:0]  cmap, enc, depth, desc;
    logic [15:0] map_len, x2, y1, y2;
    for (int k = 0; k < 12; k++) begin
      cmap = 8'd0; enc = ENC_RAW; depth = 8'd8; desc = 8'd0;
      map_len = 16'd0; x2 = 16'd2; y1 = 16'd0; y2 = 16'd2;
      case (k)
        0:  cmap = 8'd1;
        1:  enc = ENC_RAW - 8'd1;
        2:  enc = ENC_RLE + 8'd1;
        3:  x2 = 16'd0;
        4:  begin y1 = 16'd5; y2 = 16'd3; end
        5:  depth = 8'd15;
        6:  depth = 8'd0;
        7:  depth = 8'd40;
        8:  desc = MAX_DESCRIPTOR + 8'd1;
        9:  map_len = 16'h8000;
        10: map_len = 16'h0001;
        // Several checks fail at once; the colormap one takes priority.
        default: begin cmap = 8'hFF; enc = 8'd0; x2 = 16'd0; depth = 8'd3; end
      endcase
      push_header(8'd0, cmap, enc, map_len, 16'd0, y1, x2, y2, depth, desc);
      // The last case ends the file on the header's final byte.
      if (k != 11) push_noise(2);
      send_stream();
    end
  endtask

  task automatic test_raw_images();
    logic [7:0] val;
    logic [7:0] descs [4];
    descs = '{8'h00, 8'h08, 8'h20, 8'h18};
    for (int bpp = 1; bpp <= 4; bpp++) begin
      push_header((bpp == 2) ? 8'd3 : 8'd0, 8'd0, ENC_RAW, 16'd0, 16'hFFFD, 16'd0,
                  16'hFFFF, 16'd2, 8'(bpp * 8), descs[bpp - 1]);
      for (int p = 0; p < 4; p++) begin
        for (int i = 0; i < bpp; i++) begin
          if (p == 0) val = 8'h00;
          else if (p == 1) val = 8'hFF;
          else if (i == 3) val = (p == 2) ? 8'h80 : ALPHA_CLEAR;
          else val = 8'($urandom_range(0, 255));
          file_bytes.push_back(val);
        end
      end
      push_noise(2);
      send_stream();
    end
  endtask

  task automatic test_rle_images();
    // Single copy, two literal pixels, then a full-length run cut to what is left.
    push_header(8'd0, 8'd0, ENC_RLE, 16'd0, 16'd10, 16'd20, 16'd13, 16'd22, 8'd24, 8'd0);
    file_bytes.push_back(8'h80);
    push_pixel(3);
    file_bytes.push_back(8'h01);
    repeat (2) push_pixel(3);
    file_bytes.push_back(8'hFF);
    push_pixel(3);
    push_noise(3);
    send_stream();
    // A literal packet that runs past the end of a two-pixel image.
    push_header(8'd1, 8'd0, ENC_RLE, 16'd0, 16'd0, 16'd0, 16'd2, 16'd1, 8'd32, 8'd8);
    file_bytes.push_back(8'h7F);
    repeat (3) begin
      push_noise(3);
      file_bytes.push_back(8'h40);
    end
    send_stream();
  endtask

  task automatic test_extreme_sizes();
    push_header(8'd0, 8'd0, ENC_RAW, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1, 8'd8, 8'd0);
    push_noise(3);
    send_stream();
    push_header(8'd0, 8'd0, ENC_RLE, 16'd0, 16'hFFFE, 16'd0, 16'hFFFF, 16'hFFFF,
                8'd16, 8'd32);
    file_bytes.push_back(8'hFF);
    push_pixel(2);
    file_bytes.push_back(8'h00);
    push_noise(1);
    send_stream();
  endtask

  task automatic test_early_eof();
    push_noise(5);
    send_stream();
    push_noise(1);
    send_stream();
    push_header(8'd0, 8'd0, ENC_RAW, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 8'd8, 8'd0);
    send_stream();
    push_header(8'd4, 8'd0, ENC_RAW, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 8'd8, 8'd0);
    void'(file_bytes.pop_back());
    void'(file_bytes.pop_back());
    send_stream();
    push_header(8'd0, 8'd0, ENC_RLE, 16'd0, 16'd0, 16'd0, 16'd2, 16'd2, 8'd8, 8'd0);
    file_bytes.push_back(8'h83);
    send_stream();
    push_header(8'd0, 8'd0, ENC_RAW, 16'd0, 16'd0, 16'd0, 16'd2, 16'd2, 8'd24, 8'd0);
    push_noise(2);
    send_stream();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (3) begin
      push_random_image();
      send_stream();
    end
    idle_on = 1'b1;
  endtask

  // Random files fill the run up to about 1050 bytes in all.
  task automatic test_random_files();
    int target;
    int sel;
    int cut;
    target = 1050;
    while (bytes_sent < target) begin
      idle_on = ($urandom_range(0, 4) != 0);
      sel = $urandom_range(0, 9);
      if (sel <= 8) push_random_image();
      else push_noise($urandom_range(1, 30));
      if (sel == 7) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else if (sel == 8) begin
        file_bytes[$urandom_range(0, HDR_LEN - 1)] = 8'($urandom_range(0, 255));
      end
      send_stream();
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready      = 1'b0;
    for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'd0;
    restart_decoder();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_header_checks();
    wait_idle();
    test_raw_images();
    wait_idle();
    test_rle_images();
    wait_idle();
    test_extreme_sizes();
    wait_idle();
    test_early_eof();
    wait_idle();
    test_back_to_back();
    wait_idle();
    test_random_files();
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tga_pkg.sv
rtl/tga_if.sv
rtl/tga_front.sv
rtl/tga_cmd_fifo.sv
rtl/tga_back.sv
rtl/tga_stream_decoder.sv
rtl/tga_checker.sv
test/tga_stream_decoder_tb.sv
